/* rtl/iwst_pkg.sv */
// ----------------------------------------------------------------------------
// Incremental weighted sum table package
// Shared types, command codes, state encoding and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package iwst_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int INDEX_W             = 10;
    localparam int COUNT_W             = 11;
    localparam int WORD_W              = 64;
    localparam int HALF_W              = WORD_W / 2;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] entry_index;
        logic [WORD_W-1:0]  weight_in;
        logic [WORD_W-1:0]  value_in;
    } t_item;

    typedef struct packed {
        logic [WORD_W-1:0] running_sum;
        logic              index_error;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PREP,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/incremental_weighted_sum_table.sv */
// ----------------------------------------------------------------------------
// Incremental weighted sum table
// Weight and value tables in block memory with a running total of their
// products modulo 2^64, kept up to date by load and update commands.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Transfer
//  command   start, busy, i_item            start high and busy low
//  result    o_strobe, o_result             o_strobe high, one cycle only
//  config    i_cfg_valid, o_cfg_ready,      valid and ready both high
//            i_cfg_data
//
//  A load or update runs a memory read, operand preparation, three
//  passes through one shared 32x32 multiplier and a final accumulate,
//  then the result cycle, before the next command is accepted.
//  Clear, rejected and unused commands go straight to the result cycle.
//  Reset zeroes the total and the active count; the tables are not cleared.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_weighted_sum_table
    import iwst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_item              i_item,
    output logic                    o_strobe,
    output t_result                 o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COUNT_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EXT_W  = ((ADDR_W > COUNT_W) ? ADDR_W : COUNT_W) + 1;
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(TABLE_DEPTH);

    logic [WORD_W-1:0] weight_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] value_mem  [TABLE_DEPTH];

    t_state             r_state;
    t_state             n_state;
    t_item              r_item;
    logic               r_err;
    logic [COUNT_W-1:0] r_active_count;
    logic [WORD_W-1:0]  r_total;
    logic [WORD_W-1:0]  r_acc;
    logic [WORD_W-1:0]  r_mul;
    logic [WORD_W-1:0]  r_op_a;
    logic [WORD_W-1:0]  r_op_b;
    logic [WORD_W-1:0]  r_rd_weight;
    logic [WORD_W-1:0]  r_rd_value;

    logic               accept;
    logic               is_access;
    logic               in_range;
    logic [EXT_W-1:0]   in_index_ext;
    logic [EXT_W-1:0]   item_index_ext;
    logic [ADDR_W-1:0]  mem_addr;
    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [WORD_W-1:0]  mul_p;

    assign accept         = start && !busy;
    assign is_access      = (i_item.command == CMD_LOAD) || (i_item.command == CMD_UPDATE);
    assign in_index_ext   = EXT_W'(i_item.entry_index);
    assign in_range       = (in_index_ext < EXT_W'(r_active_count)) && (in_index_ext < DEPTH_EXT);
    assign item_index_ext = EXT_W'(r_item.entry_index);
    assign mem_addr       = item_index_ext[ADDR_W-1:0];

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = (r_state == S_DONE);
    assign o_result.running_sum = r_total;
    assign o_result.index_error = r_err;

    // The low 64 bits of the product need the low-by-low term in full and
    // the low 32 bits of each cross term; the high-by-high term drops out.
    always_comb begin
        case (r_state)
            S_MUL1: begin
                mul_a = r_op_a[WORD_W-1:HALF_W];
                mul_b = r_op_b[HALF_W-1:0];
            end
            S_MUL2: begin
                mul_a = r_op_a[HALF_W-1:0];
                mul_b = r_op_b[WORD_W-1:HALF_W];
            end
            default: begin
                mul_a = r_op_a[HALF_W-1:0];
                mul_b = r_op_b[HALF_W-1:0];
            end
        endcase
        mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_access && in_range) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ:  n_state = S_PREP;
            S_PREP:  n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ACC;
            S_ACC:   n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
            r_total        <= '0;
            r_err          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_err <= is_access && !in_range;
                        if (i_item.command == CMD_CLEAR) begin
                            r_total <= '0;
                        end
                    end
                end
                S_ACC: begin
                    r_total <= r_acc + {r_mul[HALF_W-1:0], {HALF_W{1'b0}}};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_mul <= mul_p;
        case (r_state)
            S_PREP: begin
                if (r_item.command == CMD_LOAD) begin
                    r_op_a <= r_item.weight_in;
                    r_op_b <= r_item.value_in;
                end else begin
                    r_op_a <= r_rd_weight;
                    r_op_b <= r_item.value_in - r_rd_value;
                end
            end
            S_MUL1: begin
                r_acc <= r_total + r_mul;
            end
            S_MUL2: begin
                r_acc <= r_acc + {r_mul[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            default: begin
            end
        endcase
    end

    // Reads and writes of an entry never overlap: one command is in flight.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_weight <= weight_mem[mem_addr];
            r_rd_value  <= value_mem[mem_addr];
        end
        if (r_state == S_PREP) begin
            value_mem[mem_addr] <= r_item.value_in;
            if (r_item.command == CMD_LOAD) begin
                weight_mem[mem_addr] <= r_item.weight_in;
            end
        end
    end

endmodule

`default_nettype wire

/* tb/incremental_weighted_sum_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Incremental weighted sum table testbench
// Sends clear, load, update and unused commands under several active counts
// with random gaps between transfers. A tracker keeps its own copy of the
// weight and value tables and of the total, and checks the total and the
// index error of every result in order.
// ----------------------------------------------------------------------------
module incremental_weighted_sum_table_tb;
    import iwst_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam int unsigned TABLE_SIZE   = 1024;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam logic [WORD_W-1:0] ONES   = {WORD_W{1'b1}};

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_item              cmd_item;
    logic               o_strobe;
    t_result            o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data;

    // Mirror of the table contents and the running total.
    class weighted_sum_tracker;
        logic [WORD_W-1:0] weight_tab [TABLE_SIZE];
        logic [WORD_W-1:0] value_tab [TABLE_SIZE];
        logic [WORD_W-1:0] total;
        int unsigned       entry_limit;
        t_result           expected_totals [$];
        int                errors;

        function new();
            total = '0;
            entry_limit = 0;
            errors = 0;
        endfunction

        function void note_count(logic [COUNT_W-1:0] count);
            entry_limit = (count > TABLE_SIZE) ? TABLE_SIZE : count;
        endfunction

        function void note_command(t_item it);
            t_result           want;
            logic [WORD_W-1:0] old_value;
            want.index_error = 1'b0;
            case (it.command)
                CMD_CLEAR: begin
                    total = '0;
                end
                CMD_LOAD, CMD_UPDATE: begin
                    if (it.entry_index >= entry_limit) begin
                        want.index_error = 1'b1;
                    end else if (it.command == CMD_LOAD) begin
                        weight_tab[it.entry_index] = it.weight_in;
                        value_tab[it.entry_index] = it.value_in;
                        total += it.weight_in * it.value_in;
                    end else begin
                        // The difference wraps modulo 2^64, like the total.
                        old_value = value_tab[it.entry_index];
                        value_tab[it.entry_index] = it.value_in;
                        total += weight_tab[it.entry_index] * (it.value_in - old_value);
                    end
                end
                default: ;
            endcase
            want.running_sum = total;
            expected_totals.push_back(want);
        endfunction

        function void check_total(t_result got);
            t_result want;
            if (expected_totals.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual sum %h error %b",
                         $time, got.running_sum, got.index_error);
                errors++;
                return;
            end
            want = expected_totals.pop_front();
            if (got.running_sum !== want.running_sum) begin
                $display("%0t: running_sum: expected %h, actual %h",
                         $time, want.running_sum, got.running_sum);
                errors++;
            end
            if (got.index_error !== want.index_error) begin
                $display("%0t: index_error: expected %b, actual %b",
                         $time, want.index_error, got.index_error);
                errors++;
            end
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction
    endclass

    weighted_sum_tracker tracker;
    int unsigned         stall_cycles = 0;
    int unsigned         cur_limit = 0;
    bit                  written [TABLE_SIZE];
    int unsigned         written_list [$];
    bit                  steady = 1'b0;

    incremental_weighted_sum_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every transfer is recorded at the edge that completes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                tracker.check_total(o_result);
            end
            if (start && !busy) begin
                tracker.note_command(cmd_item);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.note_count(i_cfg_data);
            end
            if (o_strobe || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("incremental_weighted_sum_table_tb: done, errors");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            2:       return WORD_W'($urandom_range(0, 15));
            3:       return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue(input logic [1:0] cmd, input int unsigned idx,
                         input logic [WORD_W-1:0] weight, input logic [WORD_W-1:0] value);
        t_item       it;
        int unsigned gap;
        it.command = cmd;
        it.entry_index = idx[INDEX_W-1:0];
        it.weight_in = weight;
        it.value_in = value;
        if (cmd == CMD_LOAD && idx < cur_limit && !written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
        end
        gap = steady ? 0 : rand_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        cmd_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait until every result has come back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_active_count(input logic [COUNT_W-1:0] count);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_limit = (count > TABLE_SIZE) ? TABLE_SIZE : count;
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned r;
        int unsigned idx;
        int unsigned pick;
        logic [1:0]  cmd;
        for (int unsigned k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 199) == 0) begin
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                issue(CMD_CLEAR, $urandom_range(0, TABLE_SIZE - 1), rand_word(), rand_word());
            end else if (r < 5) begin
                issue(CMD_UNUSED, $urandom_range(0, TABLE_SIZE - 1), rand_word(), rand_word());
            end else if (r < 10 && cur_limit < TABLE_SIZE) begin
                issue(2'($urandom_range(1, 2)), $urandom_range(cur_limit, TABLE_SIZE - 1),
                      rand_word(), rand_word());
            end else begin
                idx = (cur_limit == 0) ? $urandom_range(0, TABLE_SIZE - 1)
                                       : $urandom_range(0, cur_limit - 1);
                cmd = CMD_LOAD;
                if (r >= 50) begin
                    // Small tables are hit directly; large ones reuse known entries.
                    if (cur_limit != 0 && cur_limit <= 64) begin
                        if (written[idx]) cmd = CMD_UPDATE;
                    end else if (written_list.size() != 0) begin
                        pick = written_list[$urandom_range(0, written_list.size() - 1)];
                        if (pick < cur_limit) begin
                            cmd = CMD_UPDATE;
                            idx = pick;
                        end
                    end
                end
                issue(cmd, idx, rand_word(), rand_word());
            end
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] phase_counts [7];
        tracker = new();
        phase_counts = '{11'd2047, 11'd8, 11'd1, 11'd1024, 11'd700, 11'd0, 11'd37};
        i_rst_n = 1'b0;
        start = 1'b0;
        cmd_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing is in use after reset, so table commands are rejected.
        issue(CMD_LOAD, 0, ONES, ONES);
        issue(CMD_UPDATE, 0, ONES, ONES);
        issue(CMD_UNUSED, 0, '0, '0);
        issue(CMD_CLEAR, 0, '0, '0);

        write_active_count(11'd1024);
        issue(CMD_LOAD, 0, ONES, ONES);
        issue(CMD_LOAD, 1023, '0, ONES);
        issue(CMD_LOAD, 5, {1'b1, {(WORD_W - 1){1'b0}}}, 64'd3);
        issue(CMD_UPDATE, 0, rand_word(), '0);
        issue(CMD_UPDATE, 0, rand_word(), ONES);
        // A second load of an entry adds its product again.
        issue(CMD_LOAD, 0, 64'd7, 64'd9);
        issue(CMD_UPDATE, 1023, ONES, rand_word());
        issue(CMD_LOAD, 682, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(CMD_LOAD, 341, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        issue(CMD_UNUSED, 1023, ONES, ONES);
        issue(CMD_CLEAR, 1023, ONES, ONES);
        // The tables survive a clear.
        issue(CMD_UPDATE, 5, '0, 64'd1);

        // Counts above the table size act like the table size.
        write_active_count(11'd2047);
        issue(CMD_UPDATE, 1023, '0, 64'd12);
        write_active_count(11'd1);
        issue(CMD_LOAD, 1, rand_word(), rand_word());
        issue(CMD_UPDATE, 0, '0, 64'd5);
        issue(CMD_UPDATE, 1023, '0, rand_word());

        foreach (phase_counts[p]) begin
            write_active_count(phase_counts[p]);
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("incremental_weighted_sum_table_tb: done, clean");
        end else begin
            $display("incremental_weighted_sum_table_tb: done, errors");
        end
        $finish;
    end

endmodule
